// ===== hdl/pfg_pkg.sv =====
// Shared types and constants of the packet screen and flood guard.
`default_nettype none
package pfg_pkg;

  // drop reason codes
  typedef logic [3:0] reason_t;
  localparam reason_t RSN_NONE      = 4'd0;
  localparam reason_t RSN_LAND      = 4'd1;
  localparam reason_t RSN_SYNFIN    = 4'd2;
  localparam reason_t RSN_NOFLAG    = 4'd3;
  localparam reason_t RSN_FINNOACK  = 4'd4;
  localparam reason_t RSN_WINNUKE   = 4'd5;
  localparam reason_t RSN_SYNFRAG   = 4'd6;
  localparam reason_t RSN_OPTIONS   = 4'd7;
  localparam reason_t RSN_BIGICMP   = 4'd8;
  localparam reason_t RSN_SYNFLOOD  = 4'd9;
  localparam reason_t RSN_ICMPFLOOD = 4'd10;
  localparam reason_t RSN_UDPFLOOD  = 4'd11;

  // check enable bit positions (reason code minus one)
  localparam int EN_LAND      = 0;
  localparam int EN_SYNFIN    = 1;
  localparam int EN_NOFLAG    = 2;
  localparam int EN_FINNOACK  = 3;
  localparam int EN_WINNUKE   = 4;
  localparam int EN_SYNFRAG   = 5;
  localparam int EN_OPTIONS   = 6;
  localparam int EN_BIGICMP   = 7;
  localparam int EN_SYNFLOOD  = 8;
  localparam int EN_ICMPFLOOD = 9;
  localparam int EN_UDPFLOOD  = 10;
  localparam int NUM_CHECKS   = 11;

  // TCP flag bit positions
  localparam int FLAG_FIN = 0;
  localparam int FLAG_SYN = 1;
  localparam int FLAG_ACK = 4;
  localparam int FLAG_URG = 5;

  localparam logic [7:0]  PROTO_ICMP4     = 8'd1;
  localparam logic [7:0]  PROTO_NUM_TCP   = 8'd6;
  localparam logic [7:0]  PROTO_NUM_UDP   = 8'd17;
  localparam logic [7:0]  PROTO_ICMP6     = 8'd58;
  localparam logic [15:0] NETBIOS_PORT    = 16'd139;
  localparam logic [17:0] ICMP_MAX_LEN    = 18'd65535;
  localparam logic [3:0]  PLAIN_HDR_WORDS = 4'd5;

  // configuration register indexes
  typedef logic [2:0] cfg_idx_t;
  localparam cfg_idx_t CFG_CHECK_ENABLES  = 3'd0;
  localparam cfg_idx_t CFG_ZONES_SCREENED = 3'd1;
  localparam cfg_idx_t CFG_SYN_LIMIT      = 3'd2;
  localparam cfg_idx_t CFG_ICMP_LIMIT     = 3'd3;
  localparam cfg_idx_t CFG_UDP_LIMIT      = 3'd4;

  localparam int IN_TDATA_W  = 352;
  localparam int OUT_TDATA_W = 8;
  localparam int WIN_W       = 32;
  localparam int LIMIT_W     = 32;

  // verdict of the stateless stage, carried into the counter stage
  typedef struct packed {
    logic              flood;      // item reaches the counter stage
    reason_t           reason;     // stateless reason when flood is clear
    logic              syn_bump;
    logic              icmp_bump;
    logic              udp_bump;
    logic [WIN_W-1:0]  now;
  } pkt_t;

endpackage
`default_nettype wire

// ===== hdl/pfg_check.sv =====
// Stateless anomaly checks and counter selection for one packet.
`default_nettype none
module pfg_check #(
  parameter int NUM_ZONES = 64
) (
  input  wire logic [5:0]                        zone,
  input  wire logic [63:0]                       src_addr_high,
  input  wire logic [63:0]                       src_addr_low,
  input  wire logic [63:0]                       dst_addr_high,
  input  wire logic [63:0]                       dst_addr_low,
  input  wire logic [7:0]                        protocol_number,
  input  wire logic [7:0]                        tcp_flag_bits,
  input  wire logic [15:0]                       dest_port,
  input  wire logic                              fragmented,
  input  wire logic [3:0]                        ipv4_header_words,
  input  wire logic [17:0]                       packet_length,
  input  wire logic [31:0]                       now_second,
  input  wire logic [pfg_pkg::NUM_CHECKS-1:0]    check_enables,
  input  wire logic [63:0]                       zones_screened,
  input  wire logic [pfg_pkg::LIMIT_W-1:0]       syn_limit,
  input  wire logic [pfg_pkg::LIMIT_W-1:0]       icmp_limit,
  input  wire logic [pfg_pkg::LIMIT_W-1:0]       udp_limit,
  output pfg_pkg::pkt_t                          pkt
);

  logic             in_range;
  logic             screened;
  logic             is_tcp;
  logic             is_icmp;
  logic             is_udp;
  logic             f_fin, f_syn, f_ack, f_urg;
  logic             land_hit;
  logic             addr_same;
  pfg_pkg::reason_t rsn;

  assign in_range = {1'b0, zone} < 7'(NUM_ZONES);
  assign screened = in_range && zones_screened[zone] && (check_enables != '0);

  assign is_tcp  = protocol_number == pfg_pkg::PROTO_NUM_TCP;
  assign is_udp  = protocol_number == pfg_pkg::PROTO_NUM_UDP;
  assign is_icmp = (protocol_number == pfg_pkg::PROTO_ICMP4) ||
                   (protocol_number == pfg_pkg::PROTO_ICMP6);

  assign f_fin = tcp_flag_bits[pfg_pkg::FLAG_FIN];
  assign f_syn = tcp_flag_bits[pfg_pkg::FLAG_SYN];
  assign f_ack = tcp_flag_bits[pfg_pkg::FLAG_ACK];
  assign f_urg = tcp_flag_bits[pfg_pkg::FLAG_URG];

  // IPv4 compares only the low word of each address
  assign addr_same = (ipv4_header_words != 4'd0) ?
                     (src_addr_low[31:0] == dst_addr_low[31:0]) :
                     ((src_addr_high == dst_addr_high) && (src_addr_low == dst_addr_low));
  assign land_hit  = check_enables[pfg_pkg::EN_LAND] && addr_same;

  always_comb begin
    rsn = pfg_pkg::RSN_NONE;
    if (land_hit) begin
      rsn = pfg_pkg::RSN_LAND;
    end else if (is_tcp && check_enables[pfg_pkg::EN_SYNFIN] && f_syn && f_fin) begin
      rsn = pfg_pkg::RSN_SYNFIN;
    end else if (is_tcp && check_enables[pfg_pkg::EN_NOFLAG] && (tcp_flag_bits == 8'd0)) begin
      rsn = pfg_pkg::RSN_NOFLAG;
    end else if (is_tcp && check_enables[pfg_pkg::EN_FINNOACK] && f_fin && !f_ack) begin
      rsn = pfg_pkg::RSN_FINNOACK;
    end else if (is_tcp && check_enables[pfg_pkg::EN_WINNUKE] && f_urg &&
                 (dest_port == pfg_pkg::NETBIOS_PORT)) begin
      rsn = pfg_pkg::RSN_WINNUKE;
    end else if (is_tcp && check_enables[pfg_pkg::EN_SYNFRAG] && f_syn && fragmented) begin
      rsn = pfg_pkg::RSN_SYNFRAG;
    end else if (check_enables[pfg_pkg::EN_OPTIONS] &&
                 (ipv4_header_words > pfg_pkg::PLAIN_HDR_WORDS)) begin
      rsn = pfg_pkg::RSN_OPTIONS;
    end else if (check_enables[pfg_pkg::EN_BIGICMP] && is_icmp &&
                 (packet_length > pfg_pkg::ICMP_MAX_LEN)) begin
      rsn = pfg_pkg::RSN_BIGICMP;
    end
  end

  always_comb begin
    pkt.flood     = screened && (rsn == pfg_pkg::RSN_NONE);
    pkt.reason    = screened ? rsn : pfg_pkg::RSN_NONE;
    pkt.syn_bump  = check_enables[pfg_pkg::EN_SYNFLOOD] && (syn_limit != '0) &&
                    is_tcp && f_syn && !f_ack;
    pkt.icmp_bump = check_enables[pfg_pkg::EN_ICMPFLOOD] && (icmp_limit != '0) && is_icmp;
    pkt.udp_bump  = check_enables[pfg_pkg::EN_UDPFLOOD] && (udp_limit != '0) && is_udp;
    pkt.now       = now_second;
  end

endmodule
`default_nettype wire

// ===== hdl/pfg_zone_ram.sv =====
// Per-zone state memory: one write port, one registered read port, valid bits.
`default_nettype none
module pfg_zone_ram #(
  parameter int DEPTH = 64,
  parameter int AW    = 6,
  parameter int DW    = 128
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          rd_en,
  input  wire logic [AW-1:0] rd_addr,
  output logic      [DW-1:0] rd_data,
  input  wire logic          wr_en,
  input  wire logic [AW-1:0] wr_addr,
  input  wire logic [DW-1:0] wr_data
);

  logic [DW-1:0]    mem [DEPTH];
  logic [DEPTH-1:0] vld_r;
  logic [DW-1:0]    rd_q_r;
  logic             rd_vld_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_q_r <= mem[rd_addr];
    end
  end

  // entry never written reads as zero
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (wr_en) begin
        vld_r[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_vld_r <= vld_r[rd_addr];
      end
    end
  end

  assign rd_data = rd_vld_r ? rd_q_r : '0;

endmodule
`default_nettype wire

// ===== hdl/pfg_flood.sv =====
// Window rollover, saturating counter update and flood verdict for one zone entry.
`default_nettype none
module pfg_flood #(
  parameter int CB = 32
) (
  input  wire logic [3*CB+pfg_pkg::WIN_W-1:0] entry,
  input  wire pfg_pkg::pkt_t                  pkt,
  input  wire logic [pfg_pkg::LIMIT_W-1:0]    syn_limit,
  input  wire logic [pfg_pkg::LIMIT_W-1:0]    icmp_limit,
  input  wire logic [pfg_pkg::LIMIT_W-1:0]    udp_limit,
  output logic      [3*CB+pfg_pkg::WIN_W-1:0] entry_nxt,
  output pfg_pkg::reason_t                    reason
);

  localparam int CMPW = (CB > pfg_pkg::LIMIT_W) ? CB : pfg_pkg::LIMIT_W;
  localparam logic [CB-1:0] CNT_MAX = {CB{1'b1}};

  logic                      same_win;
  logic [CB-1:0]             syn_cur, icmp_cur, udp_cur;
  logic [CB-1:0]             syn_new, icmp_new, udp_new;
  logic                      syn_over, icmp_over, udp_over;

  assign same_win = entry[3*CB +: pfg_pkg::WIN_W] == pkt.now;
  assign syn_cur  = same_win ? entry[0 +: CB]    : '0;
  assign icmp_cur = same_win ? entry[CB +: CB]   : '0;
  assign udp_cur  = same_win ? entry[2*CB +: CB] : '0;

  // only one counter can move per packet: the protocol classes are disjoint
  assign syn_new  = (pkt.syn_bump && (syn_cur != CNT_MAX)) ? syn_cur + CB'(1) : syn_cur;
  assign icmp_new = (pkt.icmp_bump && (icmp_cur != CNT_MAX)) ? icmp_cur + CB'(1) : icmp_cur;
  assign udp_new  = (pkt.udp_bump && (udp_cur != CNT_MAX)) ? udp_cur + CB'(1) : udp_cur;

  assign syn_over  = pkt.syn_bump  && (CMPW'(syn_new)  > CMPW'(syn_limit));
  assign icmp_over = pkt.icmp_bump && (CMPW'(icmp_new) > CMPW'(icmp_limit));
  assign udp_over  = pkt.udp_bump  && (CMPW'(udp_new)  > CMPW'(udp_limit));

  assign entry_nxt = {pkt.now, udp_new, icmp_new, syn_new};

  always_comb begin
    if (!pkt.flood) begin
      reason = pkt.reason;
    end else if (syn_over) begin
      reason = pfg_pkg::RSN_SYNFLOOD;
    end else if (icmp_over) begin
      reason = pfg_pkg::RSN_ICMPFLOOD;
    end else if (udp_over) begin
      reason = pfg_pkg::RSN_UDPFLOOD;
    end else begin
      reason = pfg_pkg::RSN_NONE;
    end
  end

endmodule
`default_nettype wire

// ===== hdl/packet_screen_flood_guard.sv =====
// Top level of the packet screen and flood guard.
// Takes a sustained one packet descriptor per clock while the output is not
// stalled, and returns one pass/drop item per descriptor via the update stage
// and output registers. The stateless checks are done in the accept cycle
// while the zone's counter entry is read from a synchronous memory; the update
// stage updates the window and the saturating counters and writes the entry
// back as it moves on. A packet for the same zone right behind it gets the
// just-written entry through a forwarding register. The memory starts out as
// all zero through per-entry valid bits, so there is no clearing pass after
// reset. Configuration writes are taken at any time (cfg_ready is always high)
// but must only be made while no item is in flight.
`default_nettype none
module packet_screen_flood_guard #(
  parameter int NUM_ZONES  = 64,
  parameter int COUNT_BITS = 32
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  // zone[5:0], src_addr_high[69:6], src_addr_low[133:70], dst_addr_high[197:134],
  // dst_addr_low[261:198], protocol_number[269:262], tcp_flag_bits[277:270],
  // dest_port[293:278], fragmented[294], ipv4_header_words[298:295],
  // packet_length[316:299], now_second[348:317], zero[351:349]
  input  wire logic [pfg_pkg::IN_TDATA_W-1:0]   in_tdata,
  input  wire logic                             in_tvalid,
  output logic                                  in_tready,
  // drop[0], drop_reason[4:1], zero[7:5]
  output logic      [pfg_pkg::OUT_TDATA_W-1:0]  out_tdata,
  output logic                                  out_tvalid,
  input  wire logic                             out_tready,
  input  wire logic                             cfg_valid,
  output logic                                  cfg_ready,
  input  wire pfg_pkg::cfg_idx_t                cfg_index,
  input  wire logic [63:0]                      cfg_data
);

  localparam int ZW = (NUM_ZONES > 1) ? $clog2(NUM_ZONES) : 1;
  localparam int EW = 3 * COUNT_BITS + pfg_pkg::WIN_W;

  // configuration
  logic [pfg_pkg::NUM_CHECKS-1:0] check_enables_r;
  logic [63:0]                    zones_screened_r;
  logic [pfg_pkg::LIMIT_W-1:0]    syn_limit_r;
  logic [pfg_pkg::LIMIT_W-1:0]    icmp_limit_r;
  logic [pfg_pkg::LIMIT_W-1:0]    udp_limit_r;

  // pipeline
  logic             in_accept;
  logic             s1_move;
  logic             s1_vld_r;
  pfg_pkg::pkt_t    s1_pkt_r;
  logic [ZW-1:0]    s1_zone_r;
  pfg_pkg::pkt_t    chk_pkt;
  logic [ZW-1:0]    in_zone_idx;

  logic [EW-1:0]    rd_data;
  logic [EW-1:0]    cur_entry;
  logic [EW-1:0]    new_entry;
  logic             wr_en;
  logic             fwd_vld_r;
  logic [ZW-1:0]    fwd_zone_r;
  logic [EW-1:0]    fwd_data_r;
  pfg_pkg::reason_t s1_reason;

  logic             out_vld_r;
  pfg_pkg::reason_t out_reason_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      check_enables_r  <= '0;
      zones_screened_r <= '0;
      syn_limit_r      <= '0;
      icmp_limit_r     <= '0;
      udp_limit_r      <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        pfg_pkg::CFG_CHECK_ENABLES:  check_enables_r  <= cfg_data[pfg_pkg::NUM_CHECKS-1:0];
        pfg_pkg::CFG_ZONES_SCREENED: zones_screened_r <= cfg_data;
        pfg_pkg::CFG_SYN_LIMIT:      syn_limit_r      <= cfg_data[pfg_pkg::LIMIT_W-1:0];
        pfg_pkg::CFG_ICMP_LIMIT:     icmp_limit_r     <= cfg_data[pfg_pkg::LIMIT_W-1:0];
        pfg_pkg::CFG_UDP_LIMIT:      udp_limit_r      <= cfg_data[pfg_pkg::LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  pfg_check #(
    .NUM_ZONES (NUM_ZONES)
  ) u_check (
    .zone              (in_tdata[5:0]),
    .src_addr_high     (in_tdata[69:6]),
    .src_addr_low      (in_tdata[133:70]),
    .dst_addr_high     (in_tdata[197:134]),
    .dst_addr_low      (in_tdata[261:198]),
    .protocol_number   (in_tdata[269:262]),
    .tcp_flag_bits     (in_tdata[277:270]),
    .dest_port         (in_tdata[293:278]),
    .fragmented        (in_tdata[294]),
    .ipv4_header_words (in_tdata[298:295]),
    .packet_length     (in_tdata[316:299]),
    .now_second        (in_tdata[348:317]),
    .check_enables     (check_enables_r),
    .zones_screened    (zones_screened_r),
    .syn_limit         (syn_limit_r),
    .icmp_limit        (icmp_limit_r),
    .udp_limit         (udp_limit_r),
    .pkt               (chk_pkt)
  );

  assign in_zone_idx = in_tdata[ZW-1:0];

  assign s1_move   = !out_vld_r || out_tready;
  assign in_tready = !s1_vld_r || s1_move;
  assign in_accept = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (in_tready) begin
      s1_vld_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_pkt_r  <= chk_pkt;
      s1_zone_r <= in_zone_idx;
    end
  end

  pfg_zone_ram #(
    .DEPTH (NUM_ZONES),
    .AW    (ZW),
    .DW    (EW)
  ) u_ram (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (in_accept),
    .rd_addr (in_zone_idx),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (s1_zone_r),
    .wr_data (new_entry)
  );

  // last write may land on the same edge as this item's read
  assign cur_entry = (fwd_vld_r && (fwd_zone_r == s1_zone_r)) ? fwd_data_r : rd_data;

  pfg_flood #(
    .CB (COUNT_BITS)
  ) u_flood (
    .entry      (cur_entry),
    .pkt        (s1_pkt_r),
    .syn_limit  (syn_limit_r),
    .icmp_limit (icmp_limit_r),
    .udp_limit  (udp_limit_r),
    .entry_nxt  (new_entry),
    .reason     (s1_reason)
  );

  assign wr_en = s1_vld_r && s1_move && s1_pkt_r.flood;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fwd_vld_r <= 1'b0;
    end else if (wr_en) begin
      fwd_vld_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      fwd_zone_r <= s1_zone_r;
      fwd_data_r <= new_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (s1_move) begin
      out_vld_r <= s1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move && s1_vld_r) begin
      out_reason_r <= s1_reason;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {3'b000, out_reason_r, (out_reason_r != pfg_pkg::RSN_NONE)};

  // an accepted item is always in the update stage in the next cycle
  a_accept_to_s1: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept |=> s1_vld_r)
    else $error("accepted item missing from update stage");

  // a stalled update stage never takes a new item
  a_stall_blocks_in: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_vld_r && !s1_move) |-> !in_tready)
    else $error("input accepted while update stage stalled");

  // the state memory is written only by an item leaving the update stage
  a_write_on_move: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |-> (s1_vld_r && s1_move && s1_pkt_r.flood))
    else $error("state write without a moving flood-stage item");

  // flood reasons come only from items that reached the counter stage
  a_flood_reason: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_vld_r && !s1_pkt_r.flood) |->
      ((s1_reason != pfg_pkg::RSN_SYNFLOOD) && (s1_reason != pfg_pkg::RSN_ICMPFLOOD) &&
       (s1_reason != pfg_pkg::RSN_UDPFLOOD)))
    else $error("flood reason for a packet that skipped the counters");

  // an item leaving the update stage appears at the output next cycle
  a_s1_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_vld_r && s1_move) |=> out_vld_r)
    else $error("result lost between update stage and output");

endmodule
`default_nettype wire

// ===== tb/tb_packet_screen_flood_guard.sv =====
`timescale 1ns / 100ps
// Self-checking testbench of the packet screen and flood guard: predicted verdicts vs. DUT.
module tb_packet_screen_flood_guard;

  localparam int ZONES       = 64;
  localparam int LONG_HOLD   = 300;
  localparam int CYCLE_LIMIT = 250000;
  localparam logic [63:0] ALL_CHECKS   = (64'd1 << pfg_pkg::NUM_CHECKS) - 64'd1;
  localparam logic [63:0] FLOOD_CHECKS = (64'd1 << pfg_pkg::EN_SYNFLOOD) |
                                         (64'd1 << pfg_pkg::EN_ICMPFLOOD) |
                                         (64'd1 << pfg_pkg::EN_UDPFLOOD);

  typedef struct {
    logic [5:0]  zone;
    logic [63:0] src_hi;
    logic [63:0] src_lo;
    logic [63:0] dst_hi;
    logic [63:0] dst_lo;
    logic [7:0]  proto;
    logic [7:0]  flags;
    logic [15:0] port;
    logic        frag;
    logic [3:0]  hdr_words;
    logic [17:0] pkt_len;
    logic [31:0] now;
  } pkt_desc_t;

  typedef struct {
    logic             drop;
    pfg_pkg::reason_t reason;
  } verdict_t;

  // Verdict predictor plus the queue of verdicts still owed by the DUT.
  class flood_guard_sb;
    logic [10:0] enables;
    logic [63:0] zones;
    logic [31:0] syn_lim, icmp_lim, udp_lim;
    logic [31:0] syn_cnt[ZONES];
    logic [31:0] icmp_cnt[ZONES];
    logic [31:0] udp_cnt[ZONES];
    logic [31:0] win_sec[ZONES];
    verdict_t    verdict_q[$];
    int          errors;
    int          seen;

    function new();
      enables = '0;
      zones = '0;
      syn_lim = '0;
      icmp_lim = '0;
      udp_lim = '0;
      errors = 0;
      seen = 0;
      for (int z = 0; z < ZONES; z++) begin
        syn_cnt[z] = '0;
        icmp_cnt[z] = '0;
        udp_cnt[z] = '0;
        win_sec[z] = '0;
      end
    endfunction

    function void write_reg(pfg_pkg::cfg_idx_t idx, logic [63:0] v);
      case (idx)
        pfg_pkg::CFG_CHECK_ENABLES:  enables = v[10:0];
        pfg_pkg::CFG_ZONES_SCREENED: zones = v;
        pfg_pkg::CFG_SYN_LIMIT:      syn_lim = v[31:0];
        pfg_pkg::CFG_ICMP_LIMIT:     icmp_lim = v[31:0];
        pfg_pkg::CFG_UDP_LIMIT:      udp_lim = v[31:0];
        default: ;
      endcase
    endfunction

    function logic [31:0] sat_inc(logic [31:0] c);
      return (c == 32'hFFFF_FFFF) ? c : c + 32'd1;
    endfunction

    function pfg_pkg::reason_t screen(pkt_desc_t d);
      logic is_icmp;
      int   z;
      is_icmp = (d.proto == pfg_pkg::PROTO_ICMP4) || (d.proto == pfg_pkg::PROTO_ICMP6);
      z = d.zone;
      if (!zones[z] || enables == '0) return pfg_pkg::RSN_NONE;
      if (enables[pfg_pkg::EN_LAND]) begin
        // IPv4 compares only the low 32 address bits
        if (d.hdr_words != 4'd0) begin
          if (d.src_lo[31:0] == d.dst_lo[31:0]) return pfg_pkg::RSN_LAND;
        end else if (d.src_hi == d.dst_hi && d.src_lo == d.dst_lo) begin
          return pfg_pkg::RSN_LAND;
        end
      end
      if (d.proto == pfg_pkg::PROTO_NUM_TCP) begin
        if (enables[pfg_pkg::EN_SYNFIN] && d.flags[pfg_pkg::FLAG_SYN] &&
            d.flags[pfg_pkg::FLAG_FIN])
          return pfg_pkg::RSN_SYNFIN;
        if (enables[pfg_pkg::EN_NOFLAG] && d.flags == 8'd0) return pfg_pkg::RSN_NOFLAG;
        if (enables[pfg_pkg::EN_FINNOACK] && d.flags[pfg_pkg::FLAG_FIN] &&
            !d.flags[pfg_pkg::FLAG_ACK])
          return pfg_pkg::RSN_FINNOACK;
        if (enables[pfg_pkg::EN_WINNUKE] && d.flags[pfg_pkg::FLAG_URG] &&
            d.port == pfg_pkg::NETBIOS_PORT)
          return pfg_pkg::RSN_WINNUKE;
        if (enables[pfg_pkg::EN_SYNFRAG] && d.flags[pfg_pkg::FLAG_SYN] && d.frag)
          return pfg_pkg::RSN_SYNFRAG;
      end
      if (enables[pfg_pkg::EN_OPTIONS] && d.hdr_words > pfg_pkg::PLAIN_HDR_WORDS)
        return pfg_pkg::RSN_OPTIONS;
      if (enables[pfg_pkg::EN_BIGICMP] && is_icmp && d.pkt_len > pfg_pkg::ICMP_MAX_LEN)
        return pfg_pkg::RSN_BIGICMP;

      if (d.now != win_sec[z]) begin
        syn_cnt[z] = '0;
        icmp_cnt[z] = '0;
        udp_cnt[z] = '0;
        win_sec[z] = d.now;
      end
      if (enables[pfg_pkg::EN_SYNFLOOD] && syn_lim != 0 && d.proto == pfg_pkg::PROTO_NUM_TCP &&
          d.flags[pfg_pkg::FLAG_SYN] && !d.flags[pfg_pkg::FLAG_ACK]) begin
        syn_cnt[z] = sat_inc(syn_cnt[z]);
        if (syn_cnt[z] > syn_lim) return pfg_pkg::RSN_SYNFLOOD;
      end
      if (enables[pfg_pkg::EN_ICMPFLOOD] && icmp_lim != 0 && is_icmp) begin
        icmp_cnt[z] = sat_inc(icmp_cnt[z]);
        if (icmp_cnt[z] > icmp_lim) return pfg_pkg::RSN_ICMPFLOOD;
      end
      if (enables[pfg_pkg::EN_UDPFLOOD] && udp_lim != 0 &&
          d.proto == pfg_pkg::PROTO_NUM_UDP) begin
        udp_cnt[z] = sat_inc(udp_cnt[z]);
        if (udp_cnt[z] > udp_lim) return pfg_pkg::RSN_UDPFLOOD;
      end
      return pfg_pkg::RSN_NONE;
    endfunction

    function void note_input(pkt_desc_t d);
      verdict_t v;
      v.reason = screen(d);
      v.drop = (v.reason != pfg_pkg::RSN_NONE);
      verdict_q.push_back(v);
    endfunction

    function int pending();
      return verdict_q.size();
    endfunction

    task report(string msg);
      errors++;
      $display("[%0t] %s", $time, msg);
    endtask

    task check_result(logic [7:0] word);
      verdict_t want;
      seen++;
      if (verdict_q.size() == 0) begin
        report($sformatf("item %0d: verdict %02h with none outstanding", seen, word));
        return;
      end
      want = verdict_q.pop_front();
      if (word[0] !== want.drop)
        report($sformatf("item %0d: drop %b, want %b", seen, word[0], want.drop));
      if (word[4:1] !== want.reason)
        report($sformatf("item %0d: reason %0d, want %0d", seen, word[4:1], want.reason));
    endtask
  endclass

  logic                            clk = 1'b0;
  logic                            rst_n = 1'b0;
  logic [pfg_pkg::IN_TDATA_W-1:0]  in_tdata = '0;
  logic                            in_tvalid = 1'b0;
  logic                            in_tready;
  logic [pfg_pkg::OUT_TDATA_W-1:0] out_tdata;
  logic                            out_tvalid;
  logic                            out_tready = 1'b0;
  logic                            cfg_valid = 1'b0;
  logic                            cfg_ready;
  pfg_pkg::cfg_idx_t               cfg_index = pfg_pkg::CFG_CHECK_ENABLES;
  logic [63:0]                     cfg_data = '0;

  flood_guard_sb sb;
  logic          hold_req = 1'b0;
  logic          rx_calm = 1'b0;
  logic          tx_calm = 1'b0;
  int            cycle_count = 0;
  logic [31:0]   cur_sec;
  logic [5:0]    hot_zone[4];

  packet_screen_flood_guard DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tdata  (in_tdata),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .out_tdata (out_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count = cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("packet_screen_flood_guard: mismatch");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tdata);
  end

  // Result-side pacing: random stall bursts, plus one long hold on request.
  initial begin : rx_pacing
    int stall_left;
    int run_left;
    int held;
    stall_left = 0;
    run_left = 0;
    held = 0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_tready = 1'b0;
        held++;
        if (held >= LONG_HOLD) begin
          hold_req = 1'b0;
          held = 0;
        end
      end else if (stall_left > 0 && !rx_calm) begin
        out_tready = 1'b0;
        stall_left--;
      end else begin
        out_tready = 1'b1;
        if (run_left > 0) begin
          run_left--;
        end else begin
          run_left = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 120)
                                                 : $urandom_range(0, 12);
          stall_left = $urandom_range(1, 16);
        end
      end
    end
  end

  function automatic logic [pfg_pkg::IN_TDATA_W-1:0] pack_desc(pkt_desc_t d);
    return {3'b000, d.now, d.pkt_len, d.hdr_words, d.frag, d.port, d.flags, d.proto,
            d.dst_lo, d.dst_hi, d.src_lo, d.src_hi, d.zone};
  endfunction

  function automatic logic [7:0] flag_byte(bit syn, bit ack, bit fin, bit urg);
    logic [7:0] f;
    f = '0;
    f[pfg_pkg::FLAG_SYN] = syn;
    f[pfg_pkg::FLAG_ACK] = ack;
    f[pfg_pkg::FLAG_FIN] = fin;
    f[pfg_pkg::FLAG_URG] = urg;
    return f;
  endfunction

  function automatic int tx_gap();
    if (tx_calm) return 0;
    return ($urandom_range(0, 3) == 0) ? $urandom_range(1, 16) : 0;
  endfunction

  // Well-formed IPv4 packet with no anomaly; directed cases then edit its fields.
  function automatic pkt_desc_t clean_pkt(logic [5:0] zone, logic [7:0] proto,
                                          logic [7:0] flags, logic [31:0] now);
    pkt_desc_t d;
    d.zone = zone;
    d.src_hi = {$urandom, $urandom};
    d.src_lo = {$urandom, $urandom};
    d.dst_hi = {$urandom, $urandom};
    d.dst_lo = ~d.src_lo;
    d.proto = proto;
    d.flags = flags;
    d.port = 16'($urandom_range(1024, 65535));
    d.frag = 1'b0;
    d.hdr_words = pfg_pkg::PLAIN_HDR_WORDS;
    d.pkt_len = 18'd60;
    d.now = now;
    return d;
  endfunction

  function automatic pkt_desc_t rand_pkt();
    pkt_desc_t d;
    d.zone = ($urandom_range(0, 3) == 0) ? 6'($urandom) : hot_zone[$urandom_range(0, 3)];
    d.src_hi = {$urandom, $urandom};
    d.src_lo = {$urandom, $urandom};
    d.dst_hi = {$urandom, $urandom};
    d.dst_lo = {$urandom, $urandom};
    case ($urandom_range(0, 9))
      0, 1, 2, 3: d.proto = pfg_pkg::PROTO_NUM_TCP;
      4, 5:       d.proto = pfg_pkg::PROTO_NUM_UDP;
      6:          d.proto = pfg_pkg::PROTO_ICMP4;
      7:          d.proto = pfg_pkg::PROTO_ICMP6;
      default:    d.proto = 8'($urandom);
    endcase
    case ($urandom_range(0, 9))
      0, 1:    d.flags = flag_byte(1, 0, 0, 0);
      2:       d.flags = flag_byte(1, 1, 0, 0);
      3:       d.flags = flag_byte(0, 1, 0, 0);
      4:       d.flags = flag_byte(0, 1, 1, 0);
      5:       d.flags = '0;
      6:       d.flags = flag_byte(1, 0, 1, 0);
      7:       d.flags = flag_byte(0, 0, 1, 0);
      8:       d.flags = flag_byte(0, 1, 0, 1);
      default: d.flags = 8'($urandom);
    endcase
    d.port = ($urandom_range(0, 5) == 0) ? pfg_pkg::NETBIOS_PORT : 16'($urandom);
    d.frag = ($urandom_range(0, 7) == 0);
    case ($urandom_range(0, 7))
      0, 1:    d.hdr_words = 4'd0;
      2:       d.hdr_words = 4'($urandom_range(1, 15));
      default: d.hdr_words = pfg_pkg::PLAIN_HDR_WORDS;
    endcase
    // occasional LAND-like address pairs
    case ($urandom_range(0, 15))
      0: begin
        d.dst_hi = d.src_hi;
        d.dst_lo = d.src_lo;
      end
      1: d.dst_lo[31:0] = d.src_lo[31:0];
      default: ;
    endcase
    d.pkt_len = ($urandom_range(0, 5) == 0) ? 18'($urandom) : 18'($urandom_range(20, 1500));
    d.now = ($urandom_range(0, 19) == 0) ? $urandom : cur_sec;
    return d;
  endfunction

  task automatic push_pkt(pkt_desc_t d, int gap);
    in_tdata = pack_desc(d);
    in_tvalid = 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.note_input(d);
    @(negedge clk);
    if (gap > 0) begin
      in_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  task automatic drain();
    in_tvalid = 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic cfg_write(pfg_pkg::cfg_idx_t idx, logic [63:0] v);
    cfg_index = idx;
    cfg_data = v;
    cfg_valid = 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.write_reg(idx, v);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic configure(logic [63:0] en, logic [63:0] zones, logic [63:0] syn,
                           logic [63:0] icmp, logic [63:0] udp);
    drain();
    cfg_write(pfg_pkg::CFG_CHECK_ENABLES, en);
    cfg_write(pfg_pkg::CFG_ZONES_SCREENED, zones);
    cfg_write(pfg_pkg::CFG_SYN_LIMIT, syn);
    cfg_write(pfg_pkg::CFG_ICMP_LIMIT, icmp);
    cfg_write(pfg_pkg::CFG_UDP_LIMIT, udp);
  endtask

  function automatic logic [63:0] rand_limit();
    return ($urandom_range(0, 1) == 0) ? 64'($urandom_range(0, 6)) : 64'($urandom);
  endfunction

  initial begin : stimulus
    pkt_desc_t d;
    int        n_items;
    sb = new();
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed: one of each stateless check, then the flood counters
    configure(ALL_CHECKS, '1, 64'd2, 64'd1, 64'd1);
    d = clean_pkt(6'd63, pfg_pkg::PROTO_NUM_TCP, flag_byte(0, 1, 0, 0), 32'hFFFF_FFFF);
    d.dst_lo = {~d.src_lo[63:32], d.src_lo[31:0]};   // IPv4 LAND, upper bits differ
    push_pkt(d, tx_gap());
    d = clean_pkt(6'd7, pfg_pkg::PROTO_NUM_TCP, '1, 32'd100);
    d.hdr_words = 4'd0;
    d.src_hi = '1; d.src_lo = '1; d.dst_hi = '1; d.dst_lo = '1;
    d.port = '1; d.frag = 1'b1; d.pkt_len = '1;
    push_pkt(d, tx_gap());
    d = clean_pkt(6'd7, pfg_pkg::PROTO_NUM_TCP, flag_byte(0, 1, 0, 0), 32'd100);
    d.hdr_words = 4'd0;                               // IPv6, only the top half differs
    d.dst_lo = d.src_lo;
    d.dst_hi = d.src_hi ^ 64'd1;
    push_pkt(d, tx_gap());
    push_pkt(clean_pkt(6'd7, pfg_pkg::PROTO_NUM_TCP, flag_byte(1, 0, 1, 0), 32'd100),
             tx_gap());
    push_pkt(clean_pkt(6'd7, pfg_pkg::PROTO_NUM_TCP, '0, 32'd100), tx_gap());
    push_pkt(clean_pkt(6'd7, pfg_pkg::PROTO_NUM_TCP, flag_byte(0, 0, 1, 0), 32'd100),
             tx_gap());
    push_pkt(clean_pkt(6'd7, pfg_pkg::PROTO_NUM_TCP, flag_byte(0, 1, 1, 0), 32'd100),
             tx_gap());
    d = clean_pkt(6'd7, pfg_pkg::PROTO_NUM_TCP, flag_byte(0, 1, 0, 1), 32'd100);
    d.port = pfg_pkg::NETBIOS_PORT;
    push_pkt(d, tx_gap());
    d.port = pfg_pkg::NETBIOS_PORT - 16'd1;
    push_pkt(d, tx_gap());
    d = clean_pkt(6'd9, pfg_pkg::PROTO_NUM_TCP, flag_byte(1, 0, 0, 0), 32'd5);
    d.frag = 1'b1;
    push_pkt(d, tx_gap());
    d = clean_pkt(6'd7, pfg_pkg::PROTO_NUM_UDP, '0, 32'd100);
    d.hdr_words = 4'd15;
    push_pkt(d, tx_gap());
    d = clean_pkt(6'd7, pfg_pkg::PROTO_ICMP4, '0, 32'd100);
    d.hdr_words = pfg_pkg::PLAIN_HDR_WORDS + 4'd1;
    push_pkt(d, tx_gap());
    d = clean_pkt(6'd7, pfg_pkg::PROTO_ICMP4, '0, 32'd100);
    d.pkt_len = pfg_pkg::ICMP_MAX_LEN + 18'd1;
    push_pkt(d, tx_gap());
    d = clean_pkt(6'd7, pfg_pkg::PROTO_ICMP6, '0, 32'd100);
    d.pkt_len = '1;
    push_pkt(d, tx_gap());
    d = clean_pkt(6'd0, pfg_pkg::PROTO_ICMP6, '0, 32'd0);
    d.pkt_len = pfg_pkg::ICMP_MAX_LEN;
    push_pkt(d, tx_gap());
    push_pkt(clean_pkt(6'd0, pfg_pkg::PROTO_ICMP4, '0, 32'd0), tx_gap());
    repeat (3)
      push_pkt(clean_pkt(6'd9, pfg_pkg::PROTO_NUM_TCP, flag_byte(1, 0, 0, 0), 32'd5),
               tx_gap());
    push_pkt(clean_pkt(6'd9, pfg_pkg::PROTO_NUM_TCP, flag_byte(1, 0, 0, 0), 32'd6), tx_gap());
    repeat (2) push_pkt(clean_pkt(6'd9, pfg_pkg::PROTO_NUM_UDP, '0, 32'd6), tx_gap());
    push_pkt(clean_pkt(6'd7, 8'hFF, '0, 32'd100), tx_gap());
    // checks switched off, then an unscreened zone
    configure('0, '1, 64'd1, 64'd1, 64'd1);
    d = clean_pkt(6'd7, pfg_pkg::PROTO_NUM_TCP, '0, 32'd100);
    d.dst_lo = d.src_lo;
    push_pkt(d, tx_gap());
    configure(ALL_CHECKS, ~(64'd1 << 7), 64'd1, 64'd1, 64'd1);
    push_pkt(d, tx_gap());

    // random phases, each under its own register setting
    for (int p = 0; p < 6; p++) begin
      for (int k = 0; k < 4; k++) hot_zone[k] = 6'($urandom);
      cur_sec = $urandom;
      n_items = 120;
      case (p)
        0: begin
          hot_zone[0] = 6'd0;
          hot_zone[1] = 6'd63;
          cur_sec = '0;
          configure(ALL_CHECKS, '1, 64'($urandom_range(1, 4)), 64'($urandom_range(1, 4)),
                    64'($urandom_range(1, 4)));
        end
        1: configure(64'($urandom_range(0, 2047)), {$urandom, $urandom}, 64'd0,
                     64'($urandom_range(1, 4)), 64'd0);
        2: configure(ALL_CHECKS, {$urandom, $urandom}, 64'hFFFF_FFFF, 64'hFFFF_FFFF,
                     64'hFFFF_FFFF);
        3: configure(FLOOD_CHECKS, '1, 64'($urandom_range(1, 3)), 64'($urandom_range(1, 3)),
                     64'($urandom_range(1, 3)));
        4: begin
          n_items = 40;
          configure(ALL_CHECKS, '0, 64'd1, 64'd1, 64'd1);
        end
        default: configure(64'($urandom_range(1, 2047)), {$urandom, $urandom}, rand_limit(),
                           rand_limit(), rand_limit());
      endcase
      // long result-side hold while items keep coming back to back
      if (p == 2) hold_req = 1'b1;
      for (int i = 0; i < n_items; i++) begin
        if (p == 5 && i >= 60) begin
          tx_calm = 1'b1;
          rx_calm = 1'b1;
        end
        if ($urandom_range(0, 19) == 0) cur_sec = cur_sec + 32'($urandom_range(1, 2));
        push_pkt(rand_pkt(), (p == 2 && i < 40) ? 0 : tx_gap());
      end
    end

    drain();
    repeat (20) @(negedge clk);
    if (sb.pending() != 0) sb.report("verdicts still outstanding at end of run");
    if (sb.errors == 0)
      $display("packet_screen_flood_guard: match");
    else
      $display("packet_screen_flood_guard: mismatch");
    $finish;
  end

endmodule
